### sv/fcgi_nvp_pkg.sv
// Shared types and constants for the FastCGI name-value pair decoder.
package fcgi_nvp_pkg;

    localparam int LENGTH_BITS = 31;
    localparam int LEN_W       = 31;

    localparam logic [LEN_W-1:0] LEN_MASK = LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

    typedef enum logic [2:0] {
        PH_KEYLEN   = 3'd0,
        PH_VALLEN   = 3'd1,
        PH_KEY      = 3'd2,
        PH_VALUE    = 3'd3,
        PH_COMPLETE = 3'd4
    } phase_t;

    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_KEY       = 3'd1;
    localparam logic [2:0] KIND_VALUE     = 3'd2;
    localparam logic [2:0] KIND_COMPLETE  = 3'd3;
    localparam logic [2:0] KIND_MALFORMED = 3'd4;

    // last byte index of a four-byte length
    localparam logic [1:0] LEN_LAST_BYTE = 2'd3;

    typedef struct packed {
        phase_t           phase;
        logic [1:0]       len_seen;
        logic [LEN_W-1:0] len_acc;
        logic [LEN_W-1:0] key_len;
        logic [LEN_W-1:0] key_rem;
        logic [LEN_W-1:0] val_rem;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:    PH_KEYLEN,
        len_seen: 2'd0,
        len_acc:  '0,
        key_len:  '0,
        key_rem:  '0,
        val_rem:  '0
    };

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       content_byte;
        logic [LEN_W-1:0] name_length;
        logic [LEN_W-1:0] value_length;
        logic             last_of_pair;
    } result_t;

endpackage

### sv/fcgi_nvp_in_if.sv
// Input channel: one stream byte or end marker per beat.
interface fcgi_nvp_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

### sv/fcgi_nvp_out_if.sv
// Output channel: one decoded item per beat.
interface fcgi_nvp_out_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     kind;
    logic [7:0]                     content_byte;
    logic [fcgi_nvp_pkg::LEN_W-1:0] name_length;
    logic [fcgi_nvp_pkg::LEN_W-1:0] value_length;
    logic                           last_of_pair;

    modport source (output valid, output kind, output content_byte, output name_length,
                    output value_length, output last_of_pair, input ready);
    modport sink   (input valid, input kind, input content_byte, input name_length,
                    input value_length, input last_of_pair, output ready);
endinterface

### sv/fcgi_nvp_step.sv
// Next-state and result logic for one accepted beat.
module fcgi_nvp_step (
    input  fcgi_nvp_pkg::state_t  state,
    input  logic                  func,
    input  logic [7:0]            data_byte,
    output fcgi_nvp_pkg::state_t  state_next,
    output logic                  emit,
    output fcgi_nvp_pkg::result_t res
);

    logic                               len_done;
    logic [fcgi_nvp_pkg::LEN_W-1:0]     len_val;
    logic [fcgi_nvp_pkg::LEN_W-1:0]     acc_shift;
    logic [fcgi_nvp_pkg::LEN_W-1:0]     acc_upd;
    logic [1:0]                         seen_upd;
    logic [fcgi_nvp_pkg::LEN_W-1:0]     key_dec;
    logic [fcgi_nvp_pkg::LEN_W-1:0]     val_dec;
    fcgi_nvp_pkg::phase_t               phase_eff;

    // length reader: one-byte form or four-byte big-endian form
    always_comb
    begin
        acc_shift = {state.len_acc[fcgi_nvp_pkg::LEN_W-9:0], data_byte};
        len_done  = 1'b0;
        len_val   = '0;
        acc_upd   = state.len_acc;
        seen_upd  = state.len_seen;
        if (state.len_seen == 2'd0)
        begin
            if (data_byte[7])
            begin
                acc_upd  = fcgi_nvp_pkg::LEN_W'(data_byte[6:0]);
                seen_upd = 2'd1;
            end
            else
            begin
                len_done = 1'b1;
                len_val  = fcgi_nvp_pkg::LEN_W'(data_byte) & fcgi_nvp_pkg::LEN_MASK;
                acc_upd  = '0;
            end
        end
        else if (state.len_seen == fcgi_nvp_pkg::LEN_LAST_BYTE)
        begin
            len_done = 1'b1;
            len_val  = acc_shift & fcgi_nvp_pkg::LEN_MASK;
            acc_upd  = '0;
            seen_upd = 2'd0;
        end
        else
        begin
            acc_upd  = acc_shift;
            seen_upd = state.len_seen + 2'd1;
        end
    end

    always_comb
    begin
        key_dec = (state.key_rem != '0) ?
                  state.key_rem - fcgi_nvp_pkg::LEN_W'(1) : state.key_rem;
        val_dec = (state.val_rem != '0) ?
                  state.val_rem - fcgi_nvp_pkg::LEN_W'(1) : state.val_rem;
        // a data byte after completion starts a new key length
        phase_eff = (state.phase == fcgi_nvp_pkg::PH_COMPLETE) ?
                    fcgi_nvp_pkg::PH_KEYLEN : state.phase;
    end

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        res        = '0;
        if (func)
        begin
            emit = 1'b1;
            if (state.phase == fcgi_nvp_pkg::PH_KEYLEN && state.len_seen == 2'd0)
            begin
                state_next.phase = fcgi_nvp_pkg::PH_COMPLETE;
                res.kind         = fcgi_nvp_pkg::KIND_COMPLETE;
            end
            else
            begin
                state_next = fcgi_nvp_pkg::STATE_RESET;
                res.kind   = fcgi_nvp_pkg::KIND_MALFORMED;
            end
        end
        else
        begin
            case (phase_eff)
                fcgi_nvp_pkg::PH_KEYLEN:
                begin
                    state_next.phase    = fcgi_nvp_pkg::PH_KEYLEN;
                    state_next.len_acc  = acc_upd;
                    state_next.len_seen = seen_upd;
                    if (len_done)
                    begin
                        state_next.key_len = len_val;
                        state_next.key_rem = len_val;
                        state_next.phase   = fcgi_nvp_pkg::PH_VALLEN;
                    end
                end
                fcgi_nvp_pkg::PH_VALLEN:
                begin
                    state_next.len_acc  = acc_upd;
                    state_next.len_seen = seen_upd;
                    if (len_done)
                    begin
                        emit               = 1'b1;
                        state_next.val_rem = len_val;
                        if (state.key_rem != '0)
                            state_next.phase = fcgi_nvp_pkg::PH_KEY;
                        else if (len_val != '0)
                            state_next.phase = fcgi_nvp_pkg::PH_VALUE;
                        else
                            state_next.phase = fcgi_nvp_pkg::PH_KEYLEN;
                        res.kind         = fcgi_nvp_pkg::KIND_HEADER;
                        res.name_length  = state.key_len;
                        res.value_length = len_val;
                        res.last_of_pair = (state.key_rem == '0) && (len_val == '0);
                    end
                end
                fcgi_nvp_pkg::PH_KEY:
                begin
                    emit               = 1'b1;
                    state_next.key_rem = key_dec;
                    if (key_dec == '0)
                        state_next.phase = (state.val_rem != '0) ?
                                           fcgi_nvp_pkg::PH_VALUE : fcgi_nvp_pkg::PH_KEYLEN;
                    res.kind         = fcgi_nvp_pkg::KIND_KEY;
                    res.content_byte = data_byte;
                    res.last_of_pair = (key_dec == '0) && (state.val_rem == '0);
                end
                fcgi_nvp_pkg::PH_VALUE:
                begin
                    emit               = 1'b1;
                    state_next.val_rem = val_dec;
                    if (val_dec == '0)
                        state_next.phase = fcgi_nvp_pkg::PH_KEYLEN;
                    res.kind         = fcgi_nvp_pkg::KIND_VALUE;
                    res.content_byte = data_byte;
                    res.last_of_pair = (val_dec == '0);
                end
                default:
                begin
                    state_next = fcgi_nvp_pkg::STATE_RESET;
                end
            endcase
        end
    end

endmodule

### sv/fastcgi_name_value_pair_decoder.sv
// Top level of the FastCGI name-value pair decoder.
//
//   channel  modport  beat carries
//   -------  -------  ----------------------------------------------------
//   stream   sink     func, data_byte (one stream byte or end marker)
//   result   source   kind, content_byte, name_length, value_length,
//                     last_of_pair
//
// One beat is accepted per cycle while stream.ready is high; its result, if any, is
// shown on result in the cycle after, from the output register.
// The rate is set by the single pass of next-state logic (length reader,
// remaining-count decrement) between the parse state and the output register.
// stream.ready is high whenever the output register is empty or being drained.
// rst_n clears the parse state to the key-length phase and empties the output.
module fastcgi_name_value_pair_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    fcgi_nvp_in_if.sink           stream,
    fcgi_nvp_out_if.source        result
);

    fcgi_nvp_pkg::state_t  state_reg;
    fcgi_nvp_pkg::state_t  state_next;
    fcgi_nvp_pkg::result_t res_reg;
    fcgi_nvp_pkg::result_t res_next;
    logic                  valid_reg;
    logic                  emit;
    logic                  accept;

    fcgi_nvp_step u_step (
        .state      (state_reg),
        .func       (stream.func),
        .data_byte  (stream.data_byte),
        .state_next (state_next),
        .emit       (emit),
        .res        (res_next)
    );

    assign stream.ready = !valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcgi_nvp_pkg::STATE_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                valid_reg <= emit;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            res_reg <= res_next;
    end

    assign result.valid        = valid_reg;
    assign result.kind         = res_reg.kind;
    assign result.content_byte = res_reg.content_byte;
    assign result.name_length  = res_reg.name_length;
    assign result.value_length = res_reg.value_length;
    assign result.last_of_pair = res_reg.last_of_pair;

`ifndef ASSERT_OFF
    // an end marker always produces a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && stream.func |=> valid_reg)
        else $error("end marker produced no result");

    // key phase is only entered with bytes left to take
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == fcgi_nvp_pkg::PH_KEY |-> state_reg.key_rem != '0)
        else $error("key phase with zero key bytes remaining");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == fcgi_nvp_pkg::PH_VALUE |-> state_reg.val_rem != '0)
        else $error("value phase with zero value bytes remaining");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == fcgi_nvp_pkg::PH_COMPLETE |-> state_reg.len_seen == 2'd0)
        else $error("complete phase with a length pending");

    // lengths ride only on pair headers, and stream status never ends a pair
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.kind != fcgi_nvp_pkg::KIND_HEADER
        |-> res_reg.name_length == '0 && res_reg.value_length == '0)
        else $error("lengths set on a non-header result");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (res_reg.kind == fcgi_nvp_pkg::KIND_COMPLETE ||
                      res_reg.kind == fcgi_nvp_pkg::KIND_MALFORMED)
        |-> !res_reg.last_of_pair)
        else $error("last_of_pair set on a status result");
`endif

endmodule

### tb/fcgi_nvp_checker.sv
`timescale 1ns / 100ps
// Decoder checker: predicts result beats from stream beats and compares them in order.
module fcgi_nvp_checker
    import fcgi_nvp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    fcgi_nvp_in_if  stream,
    fcgi_nvp_out_if result,
    output int      errors,
    output int      outstanding
);

    // shadow parse state
    phase_t           ph;
    logic [1:0]       len_seen;
    logic [LEN_W-1:0] len_acc;
    logic [LEN_W-1:0] key_len;
    logic [LEN_W-1:0] key_rem;
    logic [LEN_W-1:0] val_rem;

    result_t awaited_items[$];

    task automatic report(input string what);
        $display("%0t ns: decoder mismatch: %s", $time, what);
        errors++;
    endtask

    function automatic void clear_parse();
        ph       = PH_KEYLEN;
        len_seen = 2'd0;
        len_acc  = '0;
        key_len  = '0;
        key_rem  = '0;
        val_rem  = '0;
    endfunction

    // Returns 1 when a length completes; one byte if bit 7 clear, else four bytes.
    function automatic bit absorb_length_byte(input logic [7:0] b,
                                              output logic [LEN_W-1:0] len);
        bit done;
        len  = '0;
        done = 1'b0;
        if (len_seen == 2'd0) begin
            if (b[7]) begin
                len_acc  = LEN_W'(b[6:0]);
                len_seen = 2'd1;
            end
            else begin
                len     = LEN_W'(b) & LEN_MASK;
                len_acc = '0;
                done    = 1'b1;
            end
        end
        else begin
            len_acc = {len_acc[LEN_W-9:0], b};
            if (len_seen == LEN_LAST_BYTE) begin
                len      = len_acc & LEN_MASK;
                len_seen = 2'd0;
                len_acc  = '0;
                done     = 1'b1;
            end
            else begin
                len_seen = len_seen + 2'd1;
            end
        end
        return done;
    endfunction

    function automatic bit decode_beat(input logic f, input logic [7:0] b,
                                       output result_t r);
        logic [LEN_W-1:0] len;
        bit               produced;
        r        = '0;
        produced = 1'b0;
        if (f) begin
            if (ph == PH_KEYLEN && len_seen == 2'd0) begin
                ph     = PH_COMPLETE;
                r.kind = KIND_COMPLETE;
            end
            else begin
                clear_parse();
                r.kind = KIND_MALFORMED;
            end
            produced = 1'b1;
        end
        else begin
            if (ph == PH_COMPLETE)
                ph = PH_KEYLEN;
            case (ph)
                PH_KEYLEN: begin
                    if (absorb_length_byte(b, len)) begin
                        key_len = len;
                        key_rem = len;
                        ph      = PH_VALLEN;
                    end
                end
                PH_VALLEN: begin
                    if (absorb_length_byte(b, len)) begin
                        val_rem = len;
                        if (key_rem != '0)
                            ph = PH_KEY;
                        else if (val_rem != '0)
                            ph = PH_VALUE;
                        else
                            ph = PH_KEYLEN;
                        r.kind         = KIND_HEADER;
                        r.name_length  = key_len;
                        r.value_length = len;
                        r.last_of_pair = (key_rem == '0 && val_rem == '0);
                        produced       = 1'b1;
                    end
                end
                PH_KEY: begin
                    if (key_rem != '0)
                        key_rem = key_rem - LEN_W'(1);
                    if (key_rem == '0)
                        ph = (val_rem != '0) ? PH_VALUE : PH_KEYLEN;
                    r.kind         = KIND_KEY;
                    r.content_byte = b;
                    r.last_of_pair = (key_rem == '0 && val_rem == '0);
                    produced       = 1'b1;
                end
                PH_VALUE: begin
                    if (val_rem != '0)
                        val_rem = val_rem - LEN_W'(1);
                    if (val_rem == '0)
                        ph = PH_KEYLEN;
                    r.kind         = KIND_VALUE;
                    r.content_byte = b;
                    r.last_of_pair = (val_rem == '0);
                    produced       = 1'b1;
                end
                default: clear_parse();
            endcase
        end
        return produced;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        result_t fresh;
        if (!rst_n) begin
            clear_parse();
            awaited_items.delete();
            outstanding <= 0;
        end
        else begin
            // drain side first: a result never belongs to a beat taken at the same edge
            if (result.valid && result.ready) begin
                got.kind         = result.kind;
                got.content_byte = result.content_byte;
                got.name_length  = result.name_length;
                got.value_length = result.value_length;
                got.last_of_pair = result.last_of_pair;
                if (awaited_items.size() == 0) begin
                    report($sformatf("unexpected result beat, kind %0d", got.kind));
                end
                else begin
                    want = awaited_items.pop_front();
                    if (got.kind != want.kind)
                        report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
                    if (got.content_byte != want.content_byte)
                        report($sformatf("content_byte %02h, wanted %02h",
                                         got.content_byte, want.content_byte));
                    if (got.name_length != want.name_length)
                        report($sformatf("name_length %0d, wanted %0d",
                                         got.name_length, want.name_length));
                    if (got.value_length != want.value_length)
                        report($sformatf("value_length %0d, wanted %0d",
                                         got.value_length, want.value_length));
                    if (got.last_of_pair != want.last_of_pair)
                        report($sformatf("last_of_pair %0b, wanted %0b",
                                         got.last_of_pair, want.last_of_pair));
                end
            end
            if (stream.valid && stream.ready) begin
                if (decode_beat(stream.func, stream.data_byte, fresh))
                    awaited_items.push_back(fresh);
            end
            outstanding <= awaited_items.size();
        end
    end

endmodule

### tb/tb_fastcgi_name_value_pair_decoder.sv
`timescale 1ns / 100ps
// Decoder testbench top: clock, reset, stream stimulus, result back-pressure and verdict.
module tb_fastcgi_name_value_pair_decoder;
    import fcgi_nvp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BEAT_TARGET = 1050;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   beats_sent = 0;
    int   errors;
    int   outstanding;
    bit   steady = 1'b0;   // both sides run without gaps while set

    fcgi_nvp_in_if  stream ();
    fcgi_nvp_out_if result ();

    fastcgi_name_value_pair_decoder i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .result (result)
    );

    fcgi_nvp_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int idle_cycles();
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    // result side back-pressure
    initial begin
        int stall;
        result.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
        end
    end

    task automatic send_beat(input logic f, input logic [7:0] b);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            stream.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream.valid     <= 1'b1;
        stream.func      <= f;
        stream.data_byte <= b;
        do @(posedge clk); while (!stream.ready);
        beats_sent++;
    endtask

    task automatic send_end();
        send_beat(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_length(input logic [LEN_W-1:0] n, input bit wide);
        if (!wide && n < 128) begin
            send_beat(1'b0, n[7:0]);
        end
        else begin
            send_beat(1'b0, {1'b1, n[30:24]});
            send_beat(1'b0, n[23:16]);
            send_beat(1'b0, n[15:8]);
            send_beat(1'b0, n[7:0]);
        end
    endtask

    // lengths, then body_beats random content bytes
    task automatic send_pair(input logic [LEN_W-1:0] k, input logic [LEN_W-1:0] v,
                             input bit kw, input bit vw, input int body_beats);
        send_length(k, kw);
        send_length(v, vw);
        for (int i = 0; i < body_beats; i++)
            send_beat(1'b0, 8'($urandom_range(0, 255)));
    endtask

    // sender holds off until every awaited result has been taken
    task automatic drain_results();
        stream.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic [LEN_W-1:0] any_length();
        case ($urandom_range(0, 2))
            0:       return LEN_W'($urandom_range(0, 9));
            1:       return LEN_W'($urandom_range(128, 70000));
            default: return LEN_W'($urandom) & LEN_MASK;
        endcase
    endfunction

    initial begin
        int               pick;
        logic [LEN_W-1:0] k;
        logic [LEN_W-1:0] v;
        rst_n            = 1'b0;
        stream.valid     = 1'b0;
        stream.func      = 1'b0;
        stream.data_byte = 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // end on a clean boundary, then end again while complete
        send_end();
        send_end();
        // empty pair
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'h00);
        // one key byte, no value
        send_beat(1'b0, 8'h01);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'hFF);
        // empty key, value follows header directly
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'h01);
        send_beat(1'b0, 8'h55);
        // widest key length, largest short value length, cut short by an end
        send_length(LEN_MASK, 1'b1);
        send_beat(1'b0, 8'h7F);
        send_beat(1'b0, 8'h80);
        send_end();
        // end inside a four-byte length
        send_beat(1'b0, 8'h80);
        send_end();
        // end while reading the value length
        send_beat(1'b0, 8'h05);
        send_end();
        // small length in four-byte form, then a clean end
        send_length(LEN_W'(1), 1'b1);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'hA5);
        send_end();
        drain_results();

        while (beats_sent < BEAT_TARGET) begin
            if ($urandom_range(0, 39) == 0)
                steady = ~steady;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                k = LEN_W'($urandom_range(0, 6));
                v = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(10, 60))
                                                : LEN_W'($urandom_range(0, 9));
                send_pair(k, v, $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                          int'(k) + int'(v));
            end
            else if (pick < 75) begin
                send_end();
            end
            else if (pick < 86) begin
                k = any_length();
                v = any_length();
                send_pair(k, v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 8));
                send_end();
            end
            else if (pick < 97) begin
                repeat ($urandom_range(1, 6))
                    send_beat(1'b0, 8'($urandom_range(0, 255)));
                send_end();
            end
            else begin
                drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
sv/fcgi_nvp_pkg.sv
sv/fcgi_nvp_in_if.sv
sv/fcgi_nvp_out_if.sv
sv/fcgi_nvp_step.sv
sv/fastcgi_name_value_pair_decoder.sv
tb/fcgi_nvp_checker.sv
tb/tb_fastcgi_name_value_pair_decoder.sv
